@@ design/lsfg_pkg.sv @@
// ----------------------------------------------------------------------------
// lsfg_pkg: shared types, constants and colour tables
// Effect codes, sparkle direction codes, controller/datapath command and
// status structs, and the fixed colour tables of the chase and palette effects.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfg_pkg;

  localparam int unsigned LedCount = 30;
  localparam int unsigned PixW     = 5;   // pixel_index width
  localparam int unsigned ChanW    = 8;   // one colour channel
  localparam int unsigned TimeW    = 16;  // elapsed and interval registers
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [PixW-1:0]    LastPix = PixW'(LedCount - 1);
  localparam logic [CfgIdxW-1:0] CfgChaseInterval   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSparkleInterval = 1'b1;
  localparam logic [TimeW-1:0]   ChaseIntervalRst   = 16'd200;
  localparam logic [TimeW-1:0]   SparkleIntervalRst = 16'd20;
  localparam logic [ChanW-1:0]   SparkleStep        = 8'd3;

  typedef enum logic [2:0] {
    EFF_WHITE_CHASE = 3'd0,
    EFF_BLUE_CHASE  = 3'd1,
    EFF_PALETTE     = 3'd2,
    EFF_SPARKLE     = 3'd3,
    EFF_CANDLE      = 3'd4,
    EFF_OFF         = 3'd5
  } effect_e;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_RISE = 2'd1,
    DIR_FALL = 2'd2
  } dir_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  // controller -> datapath
  typedef struct packed {
    logic take;  // request accepted this cycle
    logic emit;  // load the next pixel into the output register
  } lsfg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_due;  // accepted request starts a frame
    logic last;       // pixel counter sits on the last pixel
    logic out_free;   // output register can take a pixel
  } lsfg_sts_t;

  function automatic rgb_t chase_color(input logic white, input logic [1:0] idx);
    rgb_t c;
    c = '0;
    unique case (idx)
      2'd0: c = '{r: 8'd255, g: 8'd0, b: 8'd0};
      2'd1: c = '{r: 8'd0, g: 8'd255, b: 8'd0};
      2'd2: c = white ? '{r: 8'd200, g: 8'd200, b: 8'd200}
                      : '{r: 8'd0, g: 8'd0, b: 8'd255};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic rgb_t palette_color(input logic [2:0] idx);
    rgb_t c;
    c = '0;
    unique case (idx)
      3'd0: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      3'd1: c = '{r: 8'd255, g: 8'd165, b: 8'd0};
      3'd2: c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      3'd3: c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      3'd4: c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      3'd5: c = '{r: 8'd128, g: 8'd0,   b: 8'd128};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/lsfg_if.sv @@
// ----------------------------------------------------------------------------
// lsfg channel interfaces
// Valid/ready channels for requests, pixel results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfg_req_if;
  import lsfg_pkg::*;
  logic            valid;
  logic            ready;
  logic            mode;
  logic            sparkle_trigger;
  logic [PixW-1:0] sparkle_pick;
  modport source (output valid, mode, sparkle_trigger, sparkle_pick, input ready);
  modport sink   (input valid, mode, sparkle_trigger, sparkle_pick, output ready);
endinterface

interface lsfg_rsp_if;
  import lsfg_pkg::*;
  logic             valid;
  logic             ready;
  logic [PixW-1:0]  pixel_index;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic             frame_end;
  modport source (output valid, pixel_index, red, green, blue, frame_end, input ready);
  modport sink   (input valid, pixel_index, red, green, blue, frame_end, output ready);
endinterface

interface lsfg_cfg_if;
  import lsfg_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/led_strip_effect_frame_generator_unit.sv @@
// ----------------------------------------------------------------------------
// led_strip_effect_frame_generator_unit: LED strip effect frame generator
// Top level: sequencer plus datapath, wired to the request, pixel and
// register channels.
// ----------------------------------------------------------------------------
// Each request is either a 1 ms tick (mode 0) or an effect advance (mode 1).
// An advance steps through the six effects (two chases, palette rotation,
// sparkle, candle, off) and always produces a black frame; a tick produces a
// frame only when the elapsed time has reached the active effect's interval
// (candle and off never produce one). A frame is 30 pixel results, one per
// cycle unless the pixel sink stalls, through a single output register, the
// last carrying frame_end. A request that produces a frame holds off the next
// request, since the sequencer walks the pixel counter once per frame and
// accepts the next request only after the last pixel is loaded. Per-LED
// sparkle state lives in flops that reset clears directly, so the block is
// ready right out of reset. Registers (index 0 chase interval, 1 sparkle
// interval) are always accepted and should be written while no frame is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_effect_frame_generator_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lsfg_cfg_if.sink    cfg_i,
  lsfg_req_if.sink    req_i,
  lsfg_rsp_if.source  rsp_o
);
  import lsfg_pkg::*;

  lsfg_cmd_t cmd;
  lsfg_sts_t sts;

  assign cfg_i.ready = 1'b1;

  lsfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsfg_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .mode_i            (req_i.mode),
    .sparkle_trigger_i (req_i.sparkle_trigger),
    .sparkle_pick_i    (req_i.sparkle_pick),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .pixel_index_o     (rsp_o.pixel_index),
    .red_o             (rsp_o.red),
    .green_o           (rsp_o.green),
    .blue_o            (rsp_o.blue),
    .frame_end_o       (rsp_o.frame_end)
  );

endmodule

`default_nettype wire

@@ design/lsfg_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsfg_ctrl: frame sequencer
// Takes requests while idle and steps the datapath through one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfg_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire lsfg_pkg::lsfg_sts_t sts_i,
  output lsfg_pkg::lsfg_cmd_t     cmd_o
);
  import lsfg_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && sts_i.frame_due) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.take  = req_valid_i;
      end
      ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: ;
    endcase
  end

  a_no_req_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !req_ready_o)
    else $error("request taken during a frame");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("pixel loaded over a waiting result");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.last) |=> (state_q == ST_IDLE))
    else $error("frame did not end after last pixel");

  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take && sts_i.frame_due) |=> (state_q == ST_EMIT))
    else $error("frame request did not start a frame");

endmodule

`default_nettype wire

@@ design/lsfg_datapath.sv @@
// ----------------------------------------------------------------------------
// lsfg_datapath: effect state, pixel generation and output register
// Holds registers, timer, phases and per-LED sparkle state; makes one pixel
// per emit command.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfg_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // register writes
  input  wire logic                         cfg_valid_i,
  input  wire logic [lsfg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [lsfg_pkg::TimeW-1:0]   cfg_data_i,
  // request payload
  input  wire logic                         mode_i,
  input  wire logic                         sparkle_trigger_i,
  input  wire logic [lsfg_pkg::PixW-1:0]    sparkle_pick_i,
  // controller
  input  wire lsfg_pkg::lsfg_cmd_t          cmd_i,
  output lsfg_pkg::lsfg_sts_t               sts_o,
  // results
  input  wire logic                         rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic [lsfg_pkg::PixW-1:0]         pixel_index_o,
  output logic [lsfg_pkg::ChanW-1:0]        red_o,
  output logic [lsfg_pkg::ChanW-1:0]        green_o,
  output logic [lsfg_pkg::ChanW-1:0]        blue_o,
  output logic                              frame_end_o
);
  import lsfg_pkg::*;

  function automatic logic [ChanW-1:0] sat_add(input logic [ChanW-1:0] a,
                                               input logic [ChanW-1:0] b);
    logic [ChanW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ChanW] ? '1 : s[ChanW-1:0];
  endfunction

  logic [TimeW-1:0] chase_int_q, sparkle_int_q;
  effect_e          effect_q, effect_nxt;
  logic [TimeW-1:0] elapsed_q, elapsed_inc, interval;
  logic [1:0]       ph_white_q, ph_blue_q;
  logic [2:0]       ph_pal_q;
  logic [2:0]       col_q;       // colour index of the current pixel
  logic             black_q;     // frame is the all-black advance frame
  logic             trig_q;
  logic [PixW-1:0]  pick_q;
  logic [PixW-1:0]  pix_q;
  logic [ChanW-1:0] lvl_q [LedCount];
  dir_e             dir_q [LedCount];
  logic             tick_due;

  // pixel path
  logic [ChanW-1:0] lv_cur, lv_new;
  logic [ChanW:0]   lv_up;
  dir_e             dir_cur, dir_new;
  logic             hit;
  rgb_t             pix_rgb;

  logic             out_valid_q;
  logic [PixW-1:0]  out_idx_q;
  rgb_t             out_rgb_q;
  logic             out_end_q;

  // timer
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign interval    = (effect_q == EFF_SPARKLE) ? sparkle_int_q : chase_int_q;
  assign tick_due    = (effect_q == EFF_WHITE_CHASE || effect_q == EFF_BLUE_CHASE ||
                        effect_q == EFF_PALETTE || effect_q == EFF_SPARKLE) &&
                       (elapsed_inc >= interval);
  assign effect_nxt  = (effect_q == EFF_OFF) ? EFF_WHITE_CHASE : effect_e'(effect_q + 3'd1);

  assign sts_o.frame_due = mode_i || tick_due;
  assign sts_o.last      = (pix_q == LastPix);
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  // sparkle step for the current LED; a fresh trigger starts rising this frame
  always_comb begin
    lv_cur  = lvl_q[pix_q];
    dir_cur = dir_q[pix_q];
    hit     = trig_q && (pick_q == pix_q) && (dir_cur != DIR_RISE) && (dir_cur != DIR_FALL);
    lv_up   = {1'b0, lv_cur} + {1'b0, SparkleStep};
    lv_new  = lv_cur;
    dir_new = DIR_IDLE;
    if (hit || dir_cur == DIR_RISE) begin
      if (lv_up >= 9'd255) begin
        lv_new  = '1;
        dir_new = DIR_FALL;
      end else begin
        lv_new  = lv_up[ChanW-1:0];
        dir_new = DIR_RISE;
      end
    end else if (dir_cur == DIR_FALL) begin
      if (lv_cur <= SparkleStep) begin
        lv_new  = '0;
        dir_new = DIR_IDLE;
      end else begin
        lv_new  = lv_cur - SparkleStep;
        dir_new = DIR_FALL;
      end
    end
  end

  always_comb begin
    pix_rgb = '0;
    if (!black_q) begin
      unique case (effect_q)
        EFF_WHITE_CHASE: pix_rgb = chase_color(1'b1, col_q[1:0]);
        EFF_BLUE_CHASE:  pix_rgb = chase_color(1'b0, col_q[1:0]);
        EFF_PALETTE:     pix_rgb = palette_color(col_q);
        EFF_SPARKLE: begin
          pix_rgb.r = sat_add(8'd10, lv_new);
          pix_rgb.g = sat_add(8'd10, lv_new);
          pix_rgb.b = sat_add(8'd20, lv_new);
        end
        default: pix_rgb = '0;
      endcase
    end
  end

  // control and effect state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chase_int_q   <= ChaseIntervalRst;
      sparkle_int_q <= SparkleIntervalRst;
      effect_q      <= EFF_WHITE_CHASE;
      elapsed_q     <= '0;
      ph_white_q    <= '0;
      ph_blue_q     <= '0;
      ph_pal_q      <= '0;
      col_q         <= '0;
      black_q       <= 1'b0;
      trig_q        <= 1'b0;
      pick_q        <= '0;
      pix_q         <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < LedCount; i++) begin
        lvl_q[i] <= '0;
        dir_q[i] <= DIR_IDLE;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgChaseInterval:   chase_int_q   <= cfg_data_i;
          CfgSparkleInterval: sparkle_int_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (cmd_i.take) begin
        pix_q   <= '0;
        trig_q  <= sparkle_trigger_i;
        pick_q  <= sparkle_pick_i;
        black_q <= mode_i;
        if (mode_i) begin
          effect_q <= effect_nxt;
          if (effect_nxt == EFF_SPARKLE) begin
            for (int i = 0; i < LedCount; i++) begin
              lvl_q[i] <= '0;
              dir_q[i] <= DIR_IDLE;
            end
          end
        end else begin
          elapsed_q <= tick_due ? '0 : elapsed_inc;
          if (tick_due) begin
            unique case (effect_q)
              EFF_WHITE_CHASE: begin
                col_q      <= {1'b0, ph_white_q};
                ph_white_q <= (ph_white_q == 2'd2) ? 2'd0 : ph_white_q + 2'd1;
              end
              EFF_BLUE_CHASE: begin
                col_q     <= {1'b0, ph_blue_q};
                ph_blue_q <= (ph_blue_q == 2'd2) ? 2'd0 : ph_blue_q + 2'd1;
              end
              EFF_PALETTE: begin
                col_q    <= ph_pal_q;
                ph_pal_q <= (ph_pal_q == 3'd5) ? 3'd0 : ph_pal_q + 3'd1;
              end
              default: ;
            endcase
          end
        end
      end

      if (cmd_i.emit) begin
        pix_q <= pix_q + 1'b1;
        if (effect_q == EFF_PALETTE) begin
          col_q <= (col_q == 3'd5) ? 3'd0 : col_q + 3'd1;
        end else begin
          col_q <= (col_q == 3'd2) ? 3'd0 : col_q + 3'd1;
        end
        if (!black_q && effect_q == EFF_SPARKLE) begin
          lvl_q[pix_q] <= lv_new;
          dir_q[pix_q] <= dir_new;
        end
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q <= pix_q;
      out_rgb_q <= pix_rgb;
      out_end_q <= (pix_q == LastPix);
    end
  end

  assign rsp_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_o         = out_rgb_q.r;
  assign green_o       = out_rgb_q.g;
  assign blue_o        = out_rgb_q.b;
  assign frame_end_o   = out_end_q;

endmodule

`default_nettype wire
